// ===== rtl/core/wct_pkg.sv =====
// ----------------------------------------------------------------------------
// wct_pkg
// Shared types, codes and byte constants of the command line tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package wct_pkg;

  // Default width of the pending backslash counter
  localparam int RUN_COUNT_BITS_DEF = 16;

  // Most results one item can cause
  localparam int RES_MAX = 3;

  // Result kinds
  localparam logic [1:0] KIND_BYTES  = 2'd0;
  localparam logic [1:0] KIND_ARGEND = 2'd1;
  localparam logic [1:0] KIND_EOL    = 2'd2;

  // Scan modes
  localparam logic [1:0] MODE_BETWEEN  = 2'd0;
  localparam logic [1:0] MODE_UNQUOTED = 2'd1;
  localparam logic [1:0] MODE_QUOTED   = 2'd2;

  // Input item functions
  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // Register selects (address bit 2)
  localparam logic REG_MARK_LINE_ENDS = 1'b0;
  localparam logic REG_FIRST_IS_CMD   = 1'b1;

  // Characters
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic mark_line_ends;
    logic first_is_command_name;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       cmd;       // backslashes literal now
    logic       qp;        // quote seen inside quotes, undecided
  } scan_ctl_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [15:0] repeat_res;
  } res_t;

  typedef struct packed {
    res_t [RES_MAX-1:0] items;
    logic [1:0]         cnt;
  } res_list_t;

endpackage

`default_nettype wire

// ===== rtl/core/wct_if.sv =====
// ----------------------------------------------------------------------------
// wct_if
// Valid/ready channels of the tokenizer: source items in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface wct_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] source_byte;

  modport source (output valid, output func, output source_byte, input ready);
  modport sink   (input valid, input func, input source_byte, output ready);
endinterface

interface wct_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [15:0] repeat_res;
  logic        last_of_run;

  modport source (output valid, output kind, output out_byte, output repeat_res,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input out_byte, input repeat_res,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wct_step.sv =====
// ----------------------------------------------------------------------------
// wct_step
// Next scan state and result list for one item (pure combinational).
// ----------------------------------------------------------------------------
`default_nettype none

module wct_step #(
  parameter int RUN_COUNT_BITS = wct_pkg::RUN_COUNT_BITS_DEF
) (
  input  wire logic                      func,
  input  wire logic [7:0]                source_byte,
  input  wire wct_pkg::cfg_t             cfg,
  input  wire wct_pkg::scan_ctl_t        ctl,
  input  wire logic [RUN_COUNT_BITS-1:0] run,
  output wct_pkg::scan_ctl_t             ctl_nxt,
  output logic [RUN_COUNT_BITS-1:0]      run_nxt,
  output wct_pkg::res_list_t             res_list
);

  typedef logic [RUN_COUNT_BITS-1:0] run_t;

  typedef struct packed {
    wct_pkg::scan_ctl_t ctl;
    run_t               run;
    wct_pkg::res_list_t lst;
  } tb_t;

  // Clamp a run count to the 16-bit repeat field
  function automatic logic [15:0] sat_rep(run_t r);
    logic [31:0] r32;
    r32 = 32'(r);
    return (r32 > 32'h0000_FFFF) ? 16'hFFFF : r32[15:0];
  endfunction

  // Append one result, drop it when the list is full
  function automatic wct_pkg::res_list_t push(wct_pkg::res_list_t l, logic [1:0] k,
                                              logic [7:0] b, logic [15:0] rep);
    wct_pkg::res_list_t o;
    o = l;
    if (l.cnt != 2'(wct_pkg::RES_MAX)) begin
      o.items[l.cnt].kind       = k;
      o.items[l.cnt].out_byte   = b;
      o.items[l.cnt].repeat_res = rep;
      o.cnt                     = l.cnt + 2'd1;
    end
    return o;
  endfunction

  function automatic logic is_sep(logic [7:0] c);
    return (c == wct_pkg::CH_SPACE) || (c == wct_pkg::CH_TAB) ||
           (c == wct_pkg::CH_CR) || (c == wct_pkg::CH_LF) || (c == wct_pkg::CH_NUL);
  endfunction

  // Handle a byte with no pending run and no pending quote
  function automatic tb_t take_byte(tb_t s, logic [7:0] c, wct_pkg::cfg_t cf);
    tb_t  o;
    logic bs_special;
    o = s;
    bs_special = (c == wct_pkg::CH_BSL) && !s.ctl.cmd;
    case (s.ctl.mode)
      wct_pkg::MODE_QUOTED: begin
        if (c == wct_pkg::CH_QUOTE) begin
          o.ctl.qp = 1'b1;
        end else if (bs_special) begin
          o.run = run_t'(1);
        end else begin
          o.lst = push(o.lst, wct_pkg::KIND_BYTES, c, 16'd1);
        end
      end
      wct_pkg::MODE_UNQUOTED: begin
        if (is_sep(c)) begin
          o.lst = push(o.lst, wct_pkg::KIND_ARGEND, 8'd0, 16'd0);
          if (c == wct_pkg::CH_LF) begin
            o.ctl.cmd = cf.first_is_command_name;
            if (cf.mark_line_ends) begin
              o.lst = push(o.lst, wct_pkg::KIND_EOL, 8'd0, 16'd0);
            end
          end else begin
            o.ctl.cmd = 1'b0;
          end
          o.ctl.mode = wct_pkg::MODE_BETWEEN;
        end else if (c == wct_pkg::CH_QUOTE) begin
          o.ctl.mode = wct_pkg::MODE_QUOTED;
        end else if (bs_special) begin
          o.run = run_t'(1);
        end else begin
          o.lst = push(o.lst, wct_pkg::KIND_BYTES, c, 16'd1);
        end
      end
      default: begin
        // between arguments, unused mode code lands here too
        o.ctl.mode = wct_pkg::MODE_BETWEEN;
        if (is_sep(c)) begin
          if ((c == wct_pkg::CH_LF) && cf.mark_line_ends) begin
            o.lst = push(o.lst, wct_pkg::KIND_EOL, 8'd0, 16'd0);
          end
        end else if (c == wct_pkg::CH_QUOTE) begin
          o.ctl.mode = wct_pkg::MODE_QUOTED;
        end else if (bs_special) begin
          o.run      = run_t'(1);
          o.ctl.mode = wct_pkg::MODE_UNQUOTED;
        end else begin
          o.lst      = push(o.lst, wct_pkg::KIND_BYTES, c, 16'd1);
          o.ctl.mode = wct_pkg::MODE_UNQUOTED;
        end
      end
    endcase
    return o;
  endfunction

  tb_t  s;
  run_t half;

  always_comb begin
    s.ctl = ctl;
    s.run = run;
    s.lst = '0;
    half  = run >> 1;
    if (func == wct_pkg::FUNC_FLUSH) begin
      // Flush pending backslashes, close any open argument, clear scan state
      if (run != '0) begin
        s.lst = push(s.lst, wct_pkg::KIND_BYTES, wct_pkg::CH_BSL, sat_rep(run));
      end
      if (ctl.qp) begin
        s.ctl.mode = wct_pkg::MODE_UNQUOTED;
      end
      if ((s.ctl.mode == wct_pkg::MODE_UNQUOTED) || (s.ctl.mode == wct_pkg::MODE_QUOTED)) begin
        s.lst = push(s.lst, wct_pkg::KIND_ARGEND, 8'd0, 16'd0);
      end
      s.ctl.mode = wct_pkg::MODE_BETWEEN;
      s.ctl.cmd  = cfg.first_is_command_name;
      s.ctl.qp   = 1'b0;
      s.run      = '0;
    end else if (run != '0) begin
      if (source_byte == wct_pkg::CH_BSL) begin
        // Extend the run, hold at the maximum
        if (!(&run)) begin
          s.run = run + run_t'(1);
        end
      end else if (source_byte == wct_pkg::CH_QUOTE) begin
        s.run = '0;
        if (half != '0) begin
          s.lst = push(s.lst, wct_pkg::KIND_BYTES, wct_pkg::CH_BSL, sat_rep(half));
        end
        if (run[0]) begin
          s.lst = push(s.lst, wct_pkg::KIND_BYTES, wct_pkg::CH_QUOTE, 16'd1);
        end else begin
          s = take_byte(s, source_byte, cfg);
        end
      end else begin
        s.lst = push(s.lst, wct_pkg::KIND_BYTES, wct_pkg::CH_BSL, sat_rep(run));
        s.run = '0;
        s     = take_byte(s, source_byte, cfg);
      end
    end else if (ctl.qp) begin
      // Doubled quote gives a literal quote, anything else closes the quoted part
      s.ctl.qp = 1'b0;
      if (source_byte == wct_pkg::CH_QUOTE) begin
        s.lst = push(s.lst, wct_pkg::KIND_BYTES, wct_pkg::CH_QUOTE, 16'd1);
      end else begin
        s.ctl.mode = wct_pkg::MODE_UNQUOTED;
        s          = take_byte(s, source_byte, cfg);
      end
    end else begin
      s = take_byte(s, source_byte, cfg);
    end
  end

  assign ctl_nxt  = s.ctl;
  assign run_nxt  = s.run;
  assign res_list = s.lst;

endmodule

`default_nettype wire

// ===== rtl/core/windows_cmdline_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// windows_cmdline_tokenizer_core
// Splits a streamed command line into arguments by Windows quoting rules.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake            payload
//  in_ch     in    valid/ready          func, source_byte
//  out_ch    out   valid/ready          kind, out_byte, repeat_res, last_of_run
//  cfg       in    APB psel/penable     paddr, pwdata -> prdata
//
//  An item updates the scan state in the cycle it is accepted; its results
//  (zero to three) land in a result register and leave one per cycle while
//  out_ch.ready is high, which also lets items with at most one result flow
//  at one item per cycle; an item with more holds the register until its last goes.
//  A new item is taken in the same cycle the last pending result is taken.
//  rst_n is synchronous; it clears the scan state and both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module windows_cmdline_tokenizer_core #(
  parameter int RUN_COUNT_BITS = wct_pkg::RUN_COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  wct_in_if.sink           in_ch,
  wct_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  wct_pkg::cfg_t                cfg_r;
  wct_pkg::scan_ctl_t           ctl_r;
  wct_pkg::scan_ctl_t           ctl_nxt;
  logic [RUN_COUNT_BITS-1:0]    run_r;
  logic [RUN_COUNT_BITS-1:0]    run_nxt;
  wct_pkg::res_list_t           res_list;

  wct_pkg::res_t [wct_pkg::RES_MAX-1:0] bund_r;
  logic [1:0]                   bcnt_r;
  logic [1:0]                   bidx_r;

  logic in_fire;
  logic out_fire;
  logic last_res;
  logic cfg_wr;

  // Per-item scan logic
  wct_step #(
    .RUN_COUNT_BITS(RUN_COUNT_BITS)
  ) u_step (
    .func        (in_ch.func),
    .source_byte (in_ch.source_byte),
    .cfg         (cfg_r),
    .ctl         (ctl_r),
    .run         (run_r),
    .ctl_nxt     (ctl_nxt),
    .run_nxt     (run_nxt),
    .res_list    (res_list)
  );

  // Handshakes
  assign last_res    = (bidx_r + 2'd1) == bcnt_r;
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (bcnt_r == 2'd0) || (out_ch.ready && last_res);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cfg_wr      = psel && penable && pwrite;

  // Configuration registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == wct_pkg::REG_FIRST_IS_CMD) ?
                  {31'd0, cfg_r.first_is_command_name} :
                  {31'd0, cfg_r.mark_line_ends};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == wct_pkg::REG_FIRST_IS_CMD) begin
        cfg_r.first_is_command_name <= pwdata[0];
      end else begin
        cfg_r.mark_line_ends <= pwdata[0];
      end
    end
  end

  // Scan state: advance on each accepted item, else reload command-name mode on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.mode <= wct_pkg::MODE_BETWEEN;
      ctl_r.cmd  <= 1'b0;
      ctl_r.qp   <= 1'b0;
      run_r      <= '0;
    end else if (in_fire) begin
      ctl_r <= ctl_nxt;
      run_r <= run_nxt;
    end else if (cfg_wr && (paddr[2] == wct_pkg::REG_FIRST_IS_CMD)) begin
      ctl_r.cmd <= pwdata[0];
    end
  end

  // Result register: load a new list, or step through the held one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= 2'd0;
      bidx_r <= 2'd0;
    end else if (in_fire) begin
      bcnt_r <= res_list.cnt;
      bidx_r <= 2'd0;
    end else if (out_fire) begin
      if (last_res) begin
        bcnt_r <= 2'd0;
        bidx_r <= 2'd0;
      end else begin
        bidx_r <= bidx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      bund_r <= res_list.items;
    end
  end

  // Present the current result
  assign out_ch.valid       = bcnt_r != 2'd0;
  assign out_ch.kind        = bund_r[bidx_r].kind;
  assign out_ch.out_byte    = bund_r[bidx_r].out_byte;
  assign out_ch.repeat_res  = bund_r[bidx_r].repeat_res;
  assign out_ch.last_of_run = last_res;

endmodule

`default_nettype wire

// ===== tb/sv/windows_cmdline_tokenizer_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windows_cmdline_tokenizer_core_tb
// Streams command line bytes and flush items into the tokenizer, predicts the
// argument pieces, argument ends and line ends by Windows splitting rules, and
// checks every result in order under random source gaps and sink stalls.
// ----------------------------------------------------------------------------

module windows_cmdline_tokenizer_core_tb;

  localparam int RUN_BITS        = wct_pkg::RUN_COUNT_BITS_DEF;
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PHASE_ITEMS     = 110;

  typedef logic [RUN_BITS-1:0] run_t;

  typedef struct packed {
    wct_pkg::res_t res;
    logic          last;
  } token_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  wct_in_if  in_ch ();
  wct_out_if out_ch ();

  windows_cmdline_tokenizer_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Expected tokens, oldest first, and the results of the item in progress
  token_t        token_q[$];
  wct_pkg::res_t item_res[$];

  // Predicted registers and scan state
  logic       cfg_mark_eol;
  logic       cfg_first_cmd;
  logic [1:0] scan_mode_m;
  logic       cmd_name_m;
  run_t       bsl_run;
  logic       quote_wait;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned err_count    = 0;
  int unsigned quiet_cycles = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tokenizer prediction
  // ---------------------------------------------------------------------------

  function automatic logic is_separator(logic [7:0] c);
    return c == wct_pkg::CH_SPACE || c == wct_pkg::CH_TAB || c == wct_pkg::CH_CR ||
           c == wct_pkg::CH_LF || c == wct_pkg::CH_NUL;
  endfunction

  function automatic void add_result(logic [1:0] k, logic [7:0] b, run_t n);
    wct_pkg::res_t r;
    if (item_res.size() >= wct_pkg::RES_MAX) return;
    r.kind     = k;
    r.out_byte = b;
    if (n > 'hFFFF) r.repeat_res = 16'hFFFF;
    else r.repeat_res = 16'(n);
    item_res = {item_res, r};
  endfunction

  function automatic void reset_scan();
    scan_mode_m = wct_pkg::MODE_BETWEEN;
    cmd_name_m  = cfg_first_cmd;
    bsl_run     = '0;
    quote_wait  = 1'b0;
  endfunction

  // Handle a byte with no backslash run and no undecided quote
  function automatic void scan_plain(logic [7:0] c);
    logic bs_special;
    bs_special = (c == wct_pkg::CH_BSL) && !cmd_name_m;
    case (scan_mode_m)
      wct_pkg::MODE_QUOTED: begin
        if (c == wct_pkg::CH_QUOTE) quote_wait = 1'b1;
        else if (bs_special) bsl_run = run_t'(1);
        else add_result(wct_pkg::KIND_BYTES, c, run_t'(1));
      end
      wct_pkg::MODE_UNQUOTED: begin
        if (is_separator(c)) begin
          add_result(wct_pkg::KIND_ARGEND, 8'h00, run_t'(0));
          if (c == wct_pkg::CH_LF) begin
            cmd_name_m = cfg_first_cmd;
            if (cfg_mark_eol) add_result(wct_pkg::KIND_EOL, 8'h00, run_t'(0));
          end else begin
            cmd_name_m = 1'b0;
          end
          scan_mode_m = wct_pkg::MODE_BETWEEN;
        end else if (c == wct_pkg::CH_QUOTE) begin
          scan_mode_m = wct_pkg::MODE_QUOTED;
        end else if (bs_special) begin
          bsl_run = run_t'(1);
        end else begin
          add_result(wct_pkg::KIND_BYTES, c, run_t'(1));
        end
      end
      default: begin
        scan_mode_m = wct_pkg::MODE_BETWEEN;
        if (is_separator(c)) begin
          if (c == wct_pkg::CH_LF && cfg_mark_eol)
            add_result(wct_pkg::KIND_EOL, 8'h00, run_t'(0));
        end else if (c == wct_pkg::CH_QUOTE) begin
          scan_mode_m = wct_pkg::MODE_QUOTED;
        end else if (bs_special) begin
          bsl_run     = run_t'(1);
          scan_mode_m = wct_pkg::MODE_UNQUOTED;
        end else begin
          add_result(wct_pkg::KIND_BYTES, c, run_t'(1));
          scan_mode_m = wct_pkg::MODE_UNQUOTED;
        end
      end
    endcase
  endfunction

  // Advance the predicted state by one accepted item and queue its tokens
  function automatic void tokenize_item(logic f, logic [7:0] c);
    run_t   half;
    logic   odd;
    token_t t;
    item_res.delete();
    if (f == wct_pkg::FUNC_FLUSH) begin
      if (bsl_run != 0) add_result(wct_pkg::KIND_BYTES, wct_pkg::CH_BSL, bsl_run);
      if (quote_wait) scan_mode_m = wct_pkg::MODE_UNQUOTED;
      if (scan_mode_m == wct_pkg::MODE_UNQUOTED || scan_mode_m == wct_pkg::MODE_QUOTED)
        add_result(wct_pkg::KIND_ARGEND, 8'h00, run_t'(0));
      reset_scan();
    end else if (bsl_run != 0) begin
      if (c == wct_pkg::CH_BSL) begin
        if (bsl_run != '1) bsl_run = bsl_run + run_t'(1);
      end else if (c == wct_pkg::CH_QUOTE) begin
        half    = bsl_run >> 1;
        odd     = bsl_run[0];
        bsl_run = '0;
        if (half != 0) add_result(wct_pkg::KIND_BYTES, wct_pkg::CH_BSL, half);
        if (odd) add_result(wct_pkg::KIND_BYTES, wct_pkg::CH_QUOTE, run_t'(1));
        else scan_plain(c);
      end else begin
        add_result(wct_pkg::KIND_BYTES, wct_pkg::CH_BSL, bsl_run);
        bsl_run = '0;
        scan_plain(c);
      end
    end else if (quote_wait) begin
      quote_wait = 1'b0;
      if (c == wct_pkg::CH_QUOTE) begin
        add_result(wct_pkg::KIND_BYTES, wct_pkg::CH_QUOTE, run_t'(1));
      end else begin
        scan_mode_m = wct_pkg::MODE_UNQUOTED;
        scan_plain(c);
      end
    end else begin
      scan_plain(c);
    end
    foreach (item_res[i]) begin
      t.res   = item_res[i];
      t.last  = (i == item_res.size() - 1);
      token_q = {token_q, t};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls and in-order check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    token_t want;
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (token_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: kind=%0d byte=%02h rep=%0d last=%0b",
                   out_ch.kind, out_ch.out_byte, out_ch.repeat_res, out_ch.last_of_run);
      end else begin
        want = token_q.pop_front();
        if (out_ch.kind !== want.res.kind || out_ch.out_byte !== want.res.out_byte ||
            out_ch.repeat_res !== want.res.repeat_res ||
            out_ch.last_of_run !== want.last) begin
          err_count++;
          if (err_count <= 10)
            $display({"mismatch: expected kind=%0d byte=%02h rep=%0d last=%0b,",
                      " got kind=%0d byte=%02h rep=%0d last=%0b"},
                     want.res.kind, want.res.out_byte, want.res.repeat_res, want.last,
                     out_ch.kind, out_ch.out_byte, out_ch.repeat_res, out_ch.last_of_run);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Source side and register port
  // ---------------------------------------------------------------------------

  // Send one item, with a random gap first, and predict it once accepted
  task automatic send_item(input logic f, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= f;
    in_ch.source_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    tokenize_item(f, b);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item(wct_pkg::FUNC_BYTE, s[i]);
  endtask

  // Hold the source until every expected token has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (token_q.size() != 0);
  endtask

  // Drain, then let the last item settle before touching registers
  task automatic go_idle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic sel, input logic val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == wct_pkg::REG_MARK_LINE_ENDS) begin
      cfg_mark_eol = val;
    end else begin
      cfg_first_cmd = val;
      cmd_name_m    = val;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mode(input logic mark_eol, input logic first_cmd,
                          input int unsigned idle_pct, input int unsigned stall_pct);
    go_idle();
    cfg_write(wct_pkg::REG_MARK_LINE_ENDS, mark_eol);
    cfg_write(wct_pkg::REG_FIRST_IS_CMD, first_cmd);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  function automatic logic [7:0] pick_source_byte();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return 8'($urandom_range(97, 122));
    if (roll < 44) return wct_pkg::CH_SPACE;
    if (roll < 46) return wct_pkg::CH_TAB;
    if (roll < 48) return wct_pkg::CH_CR;
    if (roll < 50) return wct_pkg::CH_NUL;
    if (roll < 55) return wct_pkg::CH_LF;
    if (roll < 70) return wct_pkg::CH_QUOTE;
    if (roll < 85) return wct_pkg::CH_BSL;
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Separators, quoted parts, doubled and empty quotes, backslash runs
  task automatic test_quoting_rules();
    set_mode(1'b0, 1'b0, 0, 0);
    send_text("a \t\r\n");
    send_item(wct_pkg::FUNC_BYTE, wct_pkg::CH_NUL);
    send_text("\"x\"\"y\" \"\" \\\\\\\"\\\\\"\\z");
    send_item(wct_pkg::FUNC_BYTE, 8'hFF);
    send_item(wct_pkg::FUNC_FLUSH, 8'hA5);
  endtask

  // Command-name backslashes, line ends, newline between arguments,
  // a run cut by a newline, and a quote left undecided at flush
  task automatic test_command_name_lines();
    set_mode(1'b1, 1'b1, 37, 37);
    send_text("c\\d a \n\\x\\\n\"q\"");
    send_item(wct_pkg::FUNC_FLUSH, 8'h5A);
  endtask

  // Long backslash runs ended by a quote, by an opening quote and by a flush
  task automatic test_long_runs();
    set_mode(1'b1, 1'b0, 0, 0);
    repeat (21) send_item(wct_pkg::FUNC_BYTE, wct_pkg::CH_BSL);
    send_item(wct_pkg::FUNC_BYTE, wct_pkg::CH_QUOTE);
    send_item(wct_pkg::FUNC_BYTE, wct_pkg::CH_SPACE);
    repeat (20) send_item(wct_pkg::FUNC_BYTE, wct_pkg::CH_BSL);
    send_item(wct_pkg::FUNC_BYTE, wct_pkg::CH_QUOTE);
    repeat (7) send_item(wct_pkg::FUNC_BYTE, wct_pkg::CH_BSL);
    send_item(wct_pkg::FUNC_FLUSH, 8'h00);
  endtask

  // Random lines under each idle pattern and register setting
  task automatic test_random_lines();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_mode(1'b0, 1'b0, 0, 0);
        1: set_mode(1'b1, 1'b1, 73, 0);
        2: set_mode(1'b0, 1'b1, 0, 73);
        default: set_mode(1'b1, 1'b0, 37, 37);
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == PHASE_ITEMS / 2) wait_drained();
        if ($urandom_range(0, 49) == 0)
          send_item(wct_pkg::FUNC_FLUSH, 8'($urandom_range(0, 255)));
        else send_item(wct_pkg::FUNC_BYTE, pick_source_byte());
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.func        = wct_pkg::FUNC_BYTE;
    in_ch.source_byte = 8'h00;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    cfg_mark_eol      = 1'b0;
    cfg_first_cmd     = 1'b0;
    reset_scan();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_quoting_rules();
    test_command_name_lines();
    test_long_runs();
    test_random_lines();

    go_idle();
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/wct_pkg.sv
rtl/core/wct_if.sv
rtl/core/wct_step.sv
rtl/core/windows_cmdline_tokenizer_core.sv
tb/sv/windows_cmdline_tokenizer_core_tb.sv
